[hw/rtl/sem_pkg.sv]
`default_nettype none
package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int WID_W = 11;                      // frame_width register
    localparam int HGT_W = 13;                      // frame_height register
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int CNT_W = 23;
    localparam int PIX_W = 24;
    localparam int SUM_W = 21;                      // gx*gx + gy*gy
    localparam int GRD_W = 12;                      // signed gradient

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [SUM_W-1:0] ROOT_CAP = SUM_W'(65281);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_GRAD,
        ST_SQR,
        ST_ROOT,
        ST_ROUND
    } t_state;

    typedef struct packed {
        logic ram_we;
        logic load_win;
        logic calc_grad;
        logic calc_sqr;
        logic root_step;
        logic emit;
    } t_ctrl;

endpackage
`default_nettype wire

[hw/rtl/sobel_edge_magnitude.sv]
`default_nettype none
// 3x3 Sobel edge magnitude on an RGB raster stream.
// Input channel: i_valid / o_stall carries one word per pixel (i_kind 0) or
// one flush word (i_kind 1). Output channel: o_valid / i_stall carries one
// word with the rounded, capped magnitude per color and o_frame_end.
// Results trail the input by frame_width+1 words; after the last pixel of a
// frame, send frame_width+1 flush words to drain it. A flush word before the
// last pixel is taken and dropped.
// A word that yields no result passes the row store read and window update;
// one that yields a result goes on through gradient, square, eight steps of
// the bit-serial root and a rounding step. o_stall stays high until it is done.
// A finished result sits in the output register, so the next word is taken
// while the receiver stalls; the block waits only when a new result is ready
// and the old one is still held.
// Reset (synchronous, active low) sets width 1024, height 1 and starts a
// frame. A configuration write also restarts the frame; the row stores keep
// their contents, and stale entries read early in a frame are masked out.
module sobel_edge_magnitude (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic                       i_kind,
    input  wire logic [7:0]                 i_red,
    input  wire logic [7:0]                 i_green,
    input  wire logic [7:0]                 i_blue,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic      [7:0]                 o_edge_red,
    output logic      [7:0]                 o_edge_green,
    output logic      [7:0]                 o_edge_blue,
    output logic                            o_frame_end,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic [sem_pkg::HGT_W-1:0]  i_cfg_data
);
    import sem_pkg::*;

    t_state r_state, n_state;
    t_ctrl  ctrl;

    logic [WID_W-1:0] r_cfg_w;
    logic [HGT_W-1:0] r_cfg_h;
    logic [WID_W-1:0] eff_w;
    logic [HGT_W-1:0] eff_h;
    logic [CNT_W-1:0] total;

    logic [COL_W-1:0] r_col;
    logic [CNT_W-1:0] r_k;
    logic [COL_W-1:0] r_ocol;
    logic [ROW_W-1:0] r_orow;
    logic [PIX_W-1:0] r_pix;
    logic [PIX_W-1:0] r_win [3][3];

    logic signed [GRD_W-1:0] r_gx [3];
    logic signed [GRD_W-1:0] r_gy [3];
    logic [SUM_W-1:0]        r_s  [3];
    logic [7:0]              r_n  [3];
    logic [2:0]              r_bit;

    logic [2*PIX_W-1:0] ram_rdata;
    logic               accept, pending, ignore, emit_ok, last_out, out_free;

    always_comb begin
        eff_w = r_cfg_w;
        if (r_cfg_w == '0) begin
            eff_w = WID_W'(1);
        end else if (r_cfg_w > WID_W'(MAX_WIDTH)) begin
            eff_w = WID_W'(MAX_WIDTH);
        end
        eff_h = r_cfg_h;
        if (r_cfg_h == '0) begin
            eff_h = HGT_W'(1);
        end else if (r_cfg_h > HGT_W'(MAX_HEIGHT)) begin
            eff_h = HGT_W'(MAX_HEIGHT);
        end
    end

    assign total    = CNT_W'(eff_w * eff_h);
    assign pending  = r_k >= total;
    assign accept   = i_valid && !o_stall;
    assign ignore   = !pending && i_kind;
    assign emit_ok  = r_k >= (CNT_W'(eff_w) + CNT_W'(1));
    assign out_free = !o_valid || !i_stall;
    assign last_out = ({1'b0, r_orow} + HGT_W'(1) >= eff_h)
                   && ({1'b0, r_ocol} + WID_W'(1) >= eff_w);

    // row stores: upper in the high half, middle in the low half
    sem_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ctrl.ram_we),
        .i_waddr (r_col),
        .i_wdata ({ram_rdata[PIX_W-1:0], r_pix}),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept && !ignore) n_state = ST_LOAD;
            ST_LOAD:  n_state = emit_ok ? ST_GRAD : ST_IDLE;
            ST_GRAD:  n_state = ST_SQR;
            ST_SQR:   n_state = ST_ROOT;
            ST_ROOT:  if (r_bit == '0) n_state = ST_ROUND;
            ST_ROUND: if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl    = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE:  o_stall = 1'b0;
            ST_LOAD:  begin
                ctrl.ram_we   = 1'b1;
                ctrl.load_win = 1'b1;
            end
            ST_GRAD:  ctrl.calc_grad = 1'b1;
            ST_SQR:   ctrl.calc_sqr  = 1'b1;
            ST_ROOT:  ctrl.root_step = 1'b1;
            ST_ROUND: ctrl.emit      = out_free;
            default:  ctrl = '0;
        endcase
    end

    // gradient of the masked window, per color
    logic signed [GRD_W-1:0] v [3][3][3];
    logic signed [GRD_W-1:0] gx [3];
    logic signed [GRD_W-1:0] gy [3];
    logic top_off, bot_off, lft_off, rgt_off;

    always_comb begin
        top_off = r_orow == '0;
        bot_off = {1'b0, r_orow} + HGT_W'(1) >= eff_h;
        lft_off = r_ocol == '0;
        rgt_off = {1'b0, r_ocol} + WID_W'(1) >= eff_w;
        for (int c = 0; c < 3; c++) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if ((i == 0 && top_off) || (i == 2 && bot_off)
                        || (j == 0 && lft_off) || (j == 2 && rgt_off)) begin
                        v[c][i][j] = '0;
                    end else begin
                        v[c][i][j] = GRD_W'({4'b0, r_win[i][j][8*c +: 8]});
                    end
                end
            end
            gx[c] = (v[c][0][2] - v[c][0][0]) + ((v[c][1][2] - v[c][1][0]) <<< 1)
                  + (v[c][2][2] - v[c][2][0]);
            gy[c] = (v[c][2][0] + (v[c][2][1] <<< 1) + v[c][2][2])
                  - (v[c][0][0] + (v[c][0][1] <<< 1) + v[c][0][2]);
        end
    end

    logic signed [2*GRD_W-1:0] px [3];
    logic signed [2*GRD_W-1:0] py [3];
    logic [7:0]  trial [3];
    logic [15:0] tsq   [3];
    logic [15:0] nsq   [3];
    logic [SUM_W-1:0] diff [3];
    logic [8:0]  rnd   [3];
    logic [7:0]  res   [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            px[c]    = r_gx[c] * r_gx[c];
            py[c]    = r_gy[c] * r_gy[c];
            trial[c] = r_n[c] | (8'd1 << r_bit);
            tsq[c]   = 16'(trial[c]) * 16'(trial[c]);
            nsq[c]   = 16'(r_n[c]) * 16'(r_n[c]);
            diff[c]  = r_s[c] - SUM_W'(nsq[c]);
            rnd[c]   = (diff[c] > SUM_W'(r_n[c])) ? {1'b0, r_n[c]} + 9'd1 : {1'b0, r_n[c]};
            if (r_s[c] >= ROOT_CAP || rnd[c][8]) begin
                res[c] = 8'd255;
            end else begin
                res[c] = rnd[c][7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cfg_w  <= WID_W'(1024);
            r_cfg_h  <= HGT_W'(1);
            r_col    <= '0;
            r_k      <= '0;
            r_ocol   <= '0;
            r_orow   <= '0;
            o_valid  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            r_state <= n_state;
            if (ctrl.emit) begin
                o_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FRAME_WIDTH:  r_cfg_w <= i_cfg_data[WID_W-1:0];
                    CFG_FRAME_HEIGHT: r_cfg_h <= i_cfg_data;
                    default:          r_cfg_w <= r_cfg_w;
                endcase
                r_col  <= '0;
                r_k    <= '0;
                r_ocol <= '0;
                r_orow <= '0;
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        r_win[i][j] <= '0;
                    end
                end
            end
            if (ctrl.load_win) begin
                for (int i = 0; i < 3; i++) begin
                    r_win[i][0] <= r_win[i][1];
                    r_win[i][1] <= r_win[i][2];
                end
                r_win[0][2] <= ram_rdata[2*PIX_W-1:PIX_W];
                r_win[1][2] <= ram_rdata[PIX_W-1:0];
                r_win[2][2] <= r_pix;
                r_k <= r_k + CNT_W'(1);
                if ({1'b0, r_col} + WID_W'(1) >= eff_w) begin
                    r_col <= '0;
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            if (ctrl.emit) begin
                if (last_out) begin
                    r_col  <= '0;
                    r_k    <= '0;
                    r_ocol <= '0;
                    r_orow <= '0;
                    for (int i = 0; i < 3; i++) begin
                        for (int j = 0; j < 3; j++) begin
                            r_win[i][j] <= '0;
                        end
                    end
                end else if ({1'b0, r_ocol} + WID_W'(1) >= eff_w) begin
                    r_ocol <= '0;
                    r_orow <= r_orow + ROW_W'(1);
                end else begin
                    r_ocol <= r_ocol + COL_W'(1);
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix <= pending ? '0 : {i_blue, i_green, i_red};
        end
        for (int c = 0; c < 3; c++) begin
            if (ctrl.calc_grad) begin
                r_gx[c] <= gx[c];
                r_gy[c] <= gy[c];
            end
            if (ctrl.calc_sqr) begin
                r_s[c] <= SUM_W'(px[c]) + SUM_W'(py[c]);
                r_n[c] <= '0;
            end
            if (ctrl.root_step && ({5'b0, tsq[c]} <= r_s[c])) begin
                r_n[c] <= trial[c];
            end
        end
        if (ctrl.calc_sqr) begin
            r_bit <= 3'd7;
        end else if (ctrl.root_step) begin
            r_bit <= r_bit - 3'd1;
        end
        if (ctrl.emit) begin
            o_edge_red   <= res[0];
            o_edge_green <= res[1];
            o_edge_blue  <= res[2];
            o_frame_end  <= last_out;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/sem_ram.sv]
`default_nettype none
module sem_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[hw/rtl/sem_chk.sv]
`default_nettype none
module sem_chk (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_valid,
    input wire logic                      o_stall,
    input wire logic                      i_kind,
    input wire logic                      o_valid,
    input wire logic                      i_stall,
    input wire logic [7:0]                o_edge_red,
    input wire logic [7:0]                o_edge_green,
    input wire logic [7:0]                o_edge_blue,
    input wire logic                      o_frame_end
);
    // held word stays while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_edge_red)
            && $stable(o_edge_green) && $stable(o_edge_blue) && $stable(o_frame_end))
        else $error("held output word changed");

    // a pixel word always keeps the block busy for the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_kind |=> o_stall)
        else $error("pixel word not processed");

    // a new result only comes out of a busy block
    a_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared while idle");

    // taken word without a new one drops valid
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_stall |=> !o_valid)
        else $error("output word repeated");
endmodule

bind sobel_edge_magnitude sem_chk u_sem_chk (.*);
`default_nettype wire

[test/sem_tb_pkg.sv]
package sem_tb_pkg;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } t_edge_word;

endpackage

[test/sobel_edge_checker.sv]
module sobel_edge_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_kind,
    input  logic [7:0]                 i_red,
    input  logic [7:0]                 i_green,
    input  logic [7:0]                 i_blue,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [7:0]                 i_edge_red,
    input  logic [7:0]                 i_edge_green,
    input  logic [7:0]                 i_edge_blue,
    input  logic                       i_frame_end,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [sem_pkg::HGT_W-1:0]  i_cfg_data,
    output int                         o_errors,
    output int                         o_pending
);
    import sem_pkg::*;
    import sem_tb_pkg::*;

    logic [PIX_W-1:0] upper_line [MAX_WIDTH];
    logic [PIX_W-1:0] middle_line [MAX_WIDTH];
    logic [PIX_W-1:0] win [3][3];
    int col_pos, row_pos, emitted;
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    t_edge_word edge_fifo [$];

    assign o_pending = edge_fifo.size();

    function automatic int used_width();
        if (width_reg == 0) return 1;
        return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    endfunction

    function automatic int used_height();
        if (height_reg == 0) return 1;
        return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    endfunction

    function automatic logic [7:0] rounded_root(int sum);
        int n;
        if (sum >= 65281) return 8'd255;
        n = 0;
        while ((n + 1) * (n + 1) <= sum) n++;
        if (sum - n * n > n) n++;
        return (n > 255) ? 8'd255 : 8'(n);
    endfunction

    task automatic restart_frame();
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) win[i][j] = '0;
        col_pos = 0;
        row_pos = 0;
        emitted = 0;
    endtask

    // one accepted input word through the sliding window
    task automatic take_word(logic kind, logic [PIX_W-1:0] pix);
        int w, h, total, k, orow, ocol, gx, gy, v;
        logic [7:0] mag [3];
        t_edge_word res;
        w = used_width();
        h = used_height();
        total = w * h;
        k = row_pos * w + col_pos;
        if (k < total && kind == KIND_FLUSH) return;  // early flush is dropped
        if (k >= total) pix = '0;                     // surplus pixel acts as flush
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = upper_line[col_pos];
        win[1][2] = middle_line[col_pos];
        win[2][2] = pix;
        upper_line[col_pos] = middle_line[col_pos];
        middle_line[col_pos] = pix;
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos++;
        end else begin
            col_pos++;
        end
        if (k < w + 1 || emitted >= total) return;
        orow = emitted / w;
        ocol = emitted % w;
        for (int ch = 0; ch < 3; ch++) begin
            gx = 0;
            gy = 0;
            for (int i = 0; i < 3; i++) begin
                if ((i == 0 && orow == 0) || (i == 2 && orow + 1 >= h)) continue;
                for (int j = 0; j < 3; j++) begin
                    if ((j == 0 && ocol == 0) || (j == 2 && ocol + 1 >= w)) continue;
                    v = int'(win[i][j][8*ch +: 8]);
                    gx += v * (j - 1) * (i == 1 ? 2 : 1);
                    gy += v * (i - 1) * (j == 1 ? 2 : 1);
                end
            end
            mag[ch] = rounded_root(gx * gx + gy * gy);
        end
        emitted++;
        res.red = mag[0];
        res.green = mag[1];
        res.blue = mag[2];
        res.frame_end = (emitted >= total);
        edge_fifo.push_back(res);
        if (res.frame_end) restart_frame();
    endtask

    task automatic report(string what);
        o_errors++;
        if (o_errors <= 10) $display("mismatch: %s", what);
    endtask

    always @(posedge i_clk) begin
        t_edge_word exp_word;
        if (!i_rst_n) begin
            for (int c = 0; c < MAX_WIDTH; c++) begin
                upper_line[c] = '0;
                middle_line[c] = '0;
            end
            width_reg = WID_W'(MAX_WIDTH);
            height_reg = HGT_W'(1);
            edge_fifo.delete();
            restart_frame();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FRAME_WIDTH) width_reg = i_cfg_data[WID_W-1:0];
                else height_reg = i_cfg_data;
                restart_frame();
            end
            if (i_in_valid && !i_in_stall) take_word(i_kind, {i_blue, i_green, i_red});
            if (i_out_valid && !i_out_stall) begin
                if (edge_fifo.size() == 0) begin
                    report($sformatf("unexpected word r=%0d g=%0d b=%0d end=%0b",
                                     i_edge_red, i_edge_green, i_edge_blue, i_frame_end));
                end else begin
                    exp_word = edge_fifo.pop_front();
                    if (exp_word.red !== i_edge_red || exp_word.green !== i_edge_green ||
                        exp_word.blue !== i_edge_blue || exp_word.frame_end !== i_frame_end)
                        report($sformatf("exp r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
                                         exp_word.red, exp_word.green, exp_word.blue,
                                         exp_word.frame_end, i_edge_red, i_edge_green,
                                         i_edge_blue, i_frame_end));
                end
            end
        end
    end

    initial o_errors = 0;

endmodule

[test/sobel_edge_magnitude_tb.sv]
module sobel_edge_magnitude_tb;
    import sem_pkg::*;
    import sem_tb_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_kind = KIND_PIXEL;
    logic [7:0] i_red = '0, i_green = '0, i_blue = '0;
    logic i_stall = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = CFG_FRAME_WIDTH;
    logic [HGT_W-1:0] i_cfg_data = '0;
    logic o_stall, o_valid, o_frame_end;
    logic [7:0] o_edge_red, o_edge_green, o_edge_blue;
    int errors, pending, cycles = 0, random_words = 0;
    bit quiet = 1'b0;

    sobel_edge_magnitude dut (.*);

    sobel_edge_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_kind(i_kind),
        .i_red(i_red), .i_green(i_green), .i_blue(i_blue),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_edge_red(o_edge_red), .i_edge_green(o_edge_green), .i_edge_blue(o_edge_blue),
        .i_frame_end(o_frame_end),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        i_stall <= quiet ? 1'b0 : ($urandom_range(99) < 15);
        if (cycles > CYCLE_LIMIT) begin
            $display("sobel_edge_magnitude_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [7:0] channel_value();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_word(logic kind);
        if (!quiet && $urandom_range(99) < 15) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_red <= channel_value();
        i_green <= channel_value();
        i_blue <= channel_value();
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // drain, let the last no-result word settle, then write a register
    task automatic write_reg(logic idx, int value);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= HGT_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_size(int w, int h);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
    endtask

    // one frame of w*h pixels, then w+1 draining words; messy adds early
    // flushes, surplus pixels and truncated frames
    task automatic play_frame(int w, int h, bit messy);
        int npix;
        npix = w * h;
        if (messy && $urandom_range(9) == 0) npix = $urandom_range(npix);
        for (int p = 0; p < npix; p++) begin
            if (messy && $urandom_range(19) == 0) begin
                send_word(KIND_FLUSH);
                random_words++;
            end
            send_word(KIND_PIXEL);
            random_words++;
        end
        if (npix < w * h) return;
        for (int f = 0; f <= w; f++) begin
            send_word((messy && $urandom_range(3) == 0) ? KIND_PIXEL : KIND_FLUSH);
            random_words++;
        end
    endtask

    initial begin
        int w, h;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset size: 1024 x 1, one row
        quiet = 1'b1;
        play_frame(MAX_WIDTH, 1, 1'b0);
        quiet = 1'b0;
        // zero sizes count as one, with an early flush first
        set_size(0, 0);
        send_word(KIND_FLUSH);
        play_frame(1, 1, 1'b0);
        set_size(3, 3);
        send_word(KIND_FLUSH);
        play_frame(3, 3, 1'b1);
        play_frame(3, 3, 1'b0);
        // oversize registers clamp to the maximum
        set_size(2047, 2);
        play_frame(MAX_WIDTH, 2, 1'b0);
        set_size(1, 8191);
        play_frame(1, MAX_HEIGHT, 1'b0);
        set_size(2, 1);
        play_frame(2, 1, 1'b1);

        random_words = 0;
        while (random_words < 800) begin
            w = ($urandom_range(7) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            if ($urandom_range(1)) write_reg(CFG_FRAME_WIDTH, ($urandom_range(3) << WID_W) | w);
            else write_reg(CFG_FRAME_WIDTH, w);
            write_reg(CFG_FRAME_HEIGHT, h);
            quiet = ($urandom_range(5) == 0);
            repeat ($urandom_range(1, 3)) play_frame(w, h, ($urandom_range(3) == 0));
            quiet = 1'b0;
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("sobel_edge_magnitude_tb OK");
        end else begin
            $display("sobel_edge_magnitude_tb NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/sem_pkg.sv
hw/rtl/sem_ram.sv
hw/rtl/sobel_edge_magnitude.sv
hw/rtl/sem_chk.sv
test/sem_tb_pkg.sv
test/sobel_edge_checker.sv
test/sobel_edge_magnitude_tb.sv
